// ===== design/lztd_pkg.sv =====
// shared constants, types and state codes of the lz77 token decompressor
`timescale 1ns / 1ps
package lztd_pkg;

    localparam int WINDOW_BYTES = 32768;
    localparam int MAX_MATCH    = 258;
    localparam int OUT_LANES    = 8;
    localparam int QUEUE_DEPTH  = 4;

    localparam int ADDR_W  = $clog2(WINDOW_BYTES);
    localparam int DIST_W  = $clog2(WINDOW_BYTES + 1);
    localparam int LEN_W   = $clog2(MAX_MATCH + 1);
    localparam int IDX_W   = $clog2(2 * WINDOW_BYTES + 1);
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_DIST  = 3'd1;
    localparam logic [2:0] ERR_BEYOND    = 3'd2;
    localparam logic [2:0] ERR_LEN_LONG  = 3'd3;
    localparam logic [2:0] ERR_LONG_VARINT = 3'd4;
    localparam logic [2:0] ERR_TRUNCATED = 3'd5;

    localparam logic [7:0] TAG_LITERAL = 8'h00;
    localparam logic [7:0] GROUP_MASK  = 8'h7f;
    localparam logic [7:0] CONT_BIT    = 8'h80;

    typedef enum logic [2:0] {
        PH_TAG,
        PH_LITLEN,
        PH_LITDATA,
        PH_MLEN,
        PH_MDIST
    } phase_t;

    typedef enum logic [1:0] {
        CMD_LIT,
        CMD_MATCH,
        CMD_STATUS
    } cmd_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_WRITE
    } back_state_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [7:0]        lit;
        logic [LEN_W-1:0]  len;
        logic [DIST_W-1:0] distance;
        logic              status;
        logic              last;
        logic [2:0]        err;
    } cmd_t;

endpackage

// ===== design/lztd_if.sv =====
// handshake interfaces for compressed input words and decoded output words
`timescale 1ns / 1ps
interface lztd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       chunk_end;
    modport source (output valid, output in_byte, output chunk_end, input ready);
    modport sink (input valid, input in_byte, input chunk_end, output ready);
endinterface

interface lztd_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        last_of_run;
    logic        chunk_done;
    logic [2:0]  error_code;
    modport source (output valid, output out_bytes, output byte_count,
                    output last_of_run, output chunk_done, output error_code,
                    input ready);
    modport sink (input valid, input out_bytes, input byte_count,
                  input last_of_run, input chunk_done, input error_code,
                  output ready);
endinterface

// ===== design/lztd_queue.sv =====
// small command queue between token parser and copy engine
`timescale 1ns / 1ps
module lztd_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  lztd_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          avail,
    output lztd_pkg::cmd_t head
);

    lztd_pkg::cmd_t                  slots_reg [lztd_pkg::QUEUE_DEPTH];
    logic [lztd_pkg::QPTR_W-1:0]     wr_reg, wr_next;
    logic [lztd_pkg::QPTR_W-1:0]     rd_reg, rd_next;
    logic [lztd_pkg::QCNT_W-1:0]     cnt_reg, cnt_next;
    logic                            do_push, do_pop;

    function automatic logic [lztd_pkg::QCNT_W-1:0] QCNT_W_one(input logic b);
        QCNT_W_one = {{(lztd_pkg::QCNT_W-1){1'b0}}, b};
    endfunction

    assign full    = (cnt_reg == lztd_pkg::QCNT_W'(lztd_pkg::QUEUE_DEPTH));
    assign avail   = (cnt_reg != '0);
    assign head    = slots_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && avail;

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + QCNT_W_one(do_push) - QCNT_W_one(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full) else $error("command queue overflow");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> avail) else $error("pop from empty command queue");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (!push && !pop) |=> $stable(cnt_reg)) else $error("queue count drift");

endmodule

// ===== design/lztd_front.sv =====
// token parser: tags, varints and checks, at most one command per input word
`timescale 1ns / 1ps
module lztd_front
(
    input  logic           clk,
    input  logic           rst_n,
    lztd_in_if.sink        stream,
    input  logic           q_full,
    output logic           push,
    output lztd_pkg::cmd_t push_cmd
);

    localparam int PROD_W = lztd_pkg::DIST_W;

    lztd_pkg::phase_t      phase_reg, phase_next;
    logic [31:0]           accum_reg, accum_next;
    logic [2:0]            groups_reg, groups_next;
    logic [31:0]           litrem_reg, litrem_next;
    logic [lztd_pkg::LEN_W-1:0] mlen_reg, mlen_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [2:0]            err_reg, err_next;

    logic                  accept;
    logic [7:0]            b;
    logic [31:0]           fed;
    logic [2:0]            groups_inc;
    logic                  v_done, v_long;
    logic [2:0]            newerr;
    logic [PROD_W:0]       prod_sum;

    assign stream.ready = !q_full;
    assign accept       = stream.valid && !q_full;
    assign b            = stream.in_byte;
    assign groups_inc   = groups_reg + 3'd1;
    assign fed          = accum_reg
                          | ({25'd0, b[6:0] & lztd_pkg::GROUP_MASK[6:0]}
                             << (5'(groups_reg) * 5'd7));
    assign v_long       = ((b & lztd_pkg::CONT_BIT) != 8'd0) && (groups_inc >= 3'd5);
    assign v_done       = ((b & lztd_pkg::CONT_BIT) == 8'd0);

    always_comb
    begin
        phase_next  = phase_reg;
        accum_next  = accum_reg;
        groups_next = groups_reg;
        litrem_next = litrem_reg;
        mlen_next   = mlen_reg;
        prod_next   = prod_reg;
        err_next    = err_reg;
        newerr      = lztd_pkg::ERR_NONE;
        prod_sum    = '0;
        push        = 1'b0;
        push_cmd.kind     = lztd_pkg::CMD_STATUS;
        push_cmd.lit      = b;
        push_cmd.len      = mlen_reg;
        push_cmd.distance = fed[lztd_pkg::DIST_W-1:0];
        push_cmd.status   = 1'b0;
        push_cmd.last     = stream.chunk_end;
        push_cmd.err      = err_reg;
        if (accept)
        begin
            if (err_reg == lztd_pkg::ERR_NONE)
            begin
                case (phase_reg)
                    lztd_pkg::PH_TAG:
                    begin
                        phase_next  = (b == lztd_pkg::TAG_LITERAL) ?
                                      lztd_pkg::PH_LITLEN : lztd_pkg::PH_MLEN;
                        accum_next  = '0;
                        groups_next = '0;
                    end
                    lztd_pkg::PH_LITDATA:
                    begin
                        push          = 1'b1;
                        push_cmd.kind = lztd_pkg::CMD_LIT;
                        if (prod_reg < PROD_W'(lztd_pkg::WINDOW_BYTES))
                        begin
                            prod_next = prod_reg + 1'b1;
                        end
                        litrem_next = litrem_reg - 32'd1;
                        if (litrem_reg == 32'd1)
                        begin
                            phase_next = lztd_pkg::PH_TAG;
                        end
                    end
                    default:
                    begin
                        accum_next  = fed;
                        groups_next = groups_inc;
                        if (v_long)
                        begin
                            newerr = lztd_pkg::ERR_LONG_VARINT;
                        end
                        else if (v_done)
                        begin
                            accum_next  = '0;
                            groups_next = '0;
                            if (phase_reg == lztd_pkg::PH_LITLEN)
                            begin
                                litrem_next = fed;
                                phase_next  = (fed == 32'd0) ?
                                              lztd_pkg::PH_TAG : lztd_pkg::PH_LITDATA;
                            end
                            else if (phase_reg == lztd_pkg::PH_MLEN)
                            begin
                                if (fed > 32'(lztd_pkg::MAX_MATCH))
                                begin
                                    newerr = lztd_pkg::ERR_LEN_LONG;
                                end
                                else
                                begin
                                    mlen_next  = fed[lztd_pkg::LEN_W-1:0];
                                    phase_next = lztd_pkg::PH_MDIST;
                                end
                            end
                            else
                            begin
                                if (fed > 32'(lztd_pkg::WINDOW_BYTES))
                                begin
                                    newerr = lztd_pkg::ERR_BEYOND;
                                end
                                else if (fed == 32'd0 || fed > 32'(prod_reg))
                                begin
                                    newerr = lztd_pkg::ERR_BAD_DIST;
                                end
                                else
                                begin
                                    if (mlen_reg != '0)
                                    begin
                                        push          = 1'b1;
                                        push_cmd.kind = lztd_pkg::CMD_MATCH;
                                    end
                                    prod_sum = {1'b0, prod_reg}
                                               + (PROD_W + 1)'(mlen_reg);
                                    prod_next = (prod_sum >
                                                 (PROD_W + 1)'(lztd_pkg::WINDOW_BYTES)) ?
                                                PROD_W'(lztd_pkg::WINDOW_BYTES) :
                                                prod_sum[PROD_W-1:0];
                                end
                                mlen_next = '0;
                                if (newerr == lztd_pkg::ERR_NONE)
                                begin
                                    phase_next = lztd_pkg::PH_TAG;
                                end
                            end
                        end
                    end
                endcase
                if (newerr == lztd_pkg::ERR_NONE && stream.chunk_end
                    && phase_next != lztd_pkg::PH_TAG)
                begin
                    newerr = lztd_pkg::ERR_TRUNCATED;
                end
                if (newerr != lztd_pkg::ERR_NONE)
                begin
                    err_next = newerr;
                end
            end
            push_cmd.err    = err_next;
            push_cmd.status = (newerr != lztd_pkg::ERR_NONE) || stream.chunk_end;
            if (push_cmd.status)
            begin
                push = 1'b1;
            end
            if (stream.chunk_end)
            begin
                phase_next  = lztd_pkg::PH_TAG;
                accum_next  = '0;
                groups_next = '0;
                litrem_next = '0;
                mlen_next   = '0;
                prod_next   = '0;
                err_next    = lztd_pkg::ERR_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= lztd_pkg::PH_TAG;
            accum_reg  <= '0;
            groups_reg <= '0;
            litrem_reg <= '0;
            mlen_reg   <= '0;
            prod_reg   <= '0;
            err_reg    <= lztd_pkg::ERR_NONE;
        end
        else
        begin
            phase_reg  <= phase_next;
            accum_reg  <= accum_next;
            groups_reg <= groups_next;
            litrem_reg <= litrem_next;
            mlen_reg   <= mlen_next;
            prod_reg   <= prod_next;
            err_reg    <= err_next;
        end
    end

    a_prod_cap: assert property (@(posedge clk) disable iff (!rst_n)
        prod_reg <= PROD_W'(lztd_pkg::WINDOW_BYTES)) else $error("produced count past window");
    a_err_push: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && err_reg == lztd_pkg::ERR_NONE && err_next != lztd_pkg::ERR_NONE) |-> push)
        else $error("new error not reported");
    a_groups: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg == lztd_pkg::ERR_NONE) |-> (groups_reg <= 3'd4))
        else $error("varint group count out of range");

endmodule

// ===== design/lztd_back.sv =====
// copy engine: history window, lane packing and output register
`timescale 1ns / 1ps
module lztd_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           avail,
    input  lztd_pkg::cmd_t head,
    output logic           pop,
    lztd_out_if.source     result
);

    localparam int AW = lztd_pkg::ADDR_W;
    localparam int IW = lztd_pkg::IDX_W;

    lztd_pkg::back_state_t state_reg, state_next;
    logic [AW-1:0]              wp_reg, wp_next;
    logic [lztd_pkg::LEN_W-1:0] rem_reg, rem_next;
    logic [lztd_pkg::DIST_W-1:0] dist_reg, dist_next;
    logic                       last_reg, last_next;
    logic                       stat_reg, stat_next;
    logic [2:0]                 err_reg, err_next;
    logic [63:0]                data_reg, data_next;
    logic [3:0]                 cnt_reg, cnt_next;

    logic                       ov_reg, ov_next;
    logic [63:0]                ob_reg, ob_next;
    logic [3:0]                 oc_reg, oc_next;
    logic                       ol_reg, ol_next;
    logic                       od_reg, od_next;
    logic [2:0]                 oe_reg, oe_next;

    logic [7:0]                 mem [lztd_pkg::WINDOW_BYTES];
    logic [7:0]                 mem_q;
    logic                       mem_we, mem_re;
    logic [AW-1:0]              mem_waddr, mem_raddr;
    logic [7:0]                 mem_wdata;

    logic                       out_free;
    logic [IW-1:0]              idx_raw;
    logic [AW-1:0]              wp_inc;
    logic [63:0]                merged;
    logic                       fin, lanes_full;

    assign out_free = !ov_reg || result.ready;
    assign idx_raw  = IW'(wp_reg) + IW'(lztd_pkg::WINDOW_BYTES) - IW'(dist_reg);
    assign mem_raddr = (idx_raw >= IW'(lztd_pkg::WINDOW_BYTES)) ?
                       AW'(idx_raw - IW'(lztd_pkg::WINDOW_BYTES)) : AW'(idx_raw);
    assign wp_inc   = (wp_reg == AW'(lztd_pkg::WINDOW_BYTES - 1)) ? '0 : wp_reg + 1'b1;
    assign fin        = (rem_reg == lztd_pkg::LEN_W'(1));
    assign lanes_full = (cnt_reg == 4'(lztd_pkg::OUT_LANES - 1));

    always_comb
    begin
        merged = data_reg;
        merged[8 * cnt_reg +: 8] = mem_q;
    end

    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        rem_next   = rem_reg;
        dist_next  = dist_reg;
        last_next  = last_reg;
        stat_next  = stat_reg;
        err_next   = err_reg;
        data_next  = data_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg && !result.ready;
        ob_next    = ob_reg;
        oc_next    = oc_reg;
        ol_next    = ol_reg;
        od_next    = od_reg;
        oe_next    = oe_reg;
        pop        = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = wp_reg;
        mem_wdata  = head.lit;
        case (state_reg)
            lztd_pkg::BK_IDLE:
            begin
                if (avail && head.kind == lztd_pkg::CMD_MATCH)
                begin
                    pop        = 1'b1;
                    rem_next   = head.len;
                    dist_next  = head.distance;
                    last_next  = head.last;
                    stat_next  = head.status;
                    err_next   = head.err;
                    data_next  = '0;
                    cnt_next   = '0;
                    state_next = lztd_pkg::BK_READ;
                end
                else if (avail && out_free)
                begin
                    pop     = 1'b1;
                    ov_next = 1'b1;
                    ol_next = 1'b1;
                    od_next = head.last;
                    oe_next = head.status ? head.err : lztd_pkg::ERR_NONE;
                    if (head.kind == lztd_pkg::CMD_LIT)
                    begin
                        mem_we  = 1'b1;
                        wp_next = head.last ? '0 : wp_inc;
                        ob_next = {56'd0, head.lit};
                        oc_next = 4'd1;
                    end
                    else
                    begin
                        if (head.last)
                        begin
                            wp_next = '0;
                        end
                        ob_next = '0;
                        oc_next = 4'd0;
                    end
                end
            end
            lztd_pkg::BK_READ:
            begin
                mem_re     = 1'b1;
                state_next = lztd_pkg::BK_WRITE;
            end
            default:
            begin
                if (!((fin || lanes_full) && !out_free))
                begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_q;
                    wp_next   = (fin && last_reg) ? '0 : wp_inc;
                    rem_next  = rem_reg - 1'b1;
                    if (fin || lanes_full)
                    begin
                        ov_next   = 1'b1;
                        ob_next   = merged;
                        oc_next   = cnt_reg + 4'd1;
                        ol_next   = fin;
                        od_next   = fin && last_reg;
                        oe_next   = (fin && stat_reg) ? err_reg : lztd_pkg::ERR_NONE;
                        data_next = '0;
                        cnt_next  = '0;
                    end
                    else
                    begin
                        data_next = merged;
                        cnt_next  = cnt_reg + 4'd1;
                    end
                    state_next = fin ? lztd_pkg::BK_IDLE : lztd_pkg::BK_READ;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lztd_pkg::BK_IDLE;
            wp_reg    <= '0;
            rem_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            rem_reg   <= rem_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        last_reg <= last_next;
        stat_reg <= stat_next;
        err_reg  <= err_next;
        data_reg <= data_next;
        cnt_reg  <= cnt_next;
        ob_reg   <= ob_next;
        oc_reg   <= oc_next;
        ol_reg   <= ol_next;
        od_reg   <= od_next;
        oe_reg   <= oe_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q <= mem[mem_raddr];
        end
    end

    assign result.valid       = ov_reg;
    assign result.out_bytes   = ob_reg;
    assign result.byte_count  = oc_reg;
    assign result.last_of_run = ol_reg;
    assign result.chunk_done  = od_reg;
    assign result.error_code  = oe_reg;

    a_rem_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != lztd_pkg::BK_IDLE) |-> (rem_reg != '0))
        else $error("copy running with no bytes left");
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && (od_reg || oe_reg != lztd_pkg::ERR_NONE)) |-> ol_reg)
        else $error("status on a word that is not last");
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != lztd_pkg::BK_IDLE) |-> !pop)
        else $error("command taken during copy");

endmodule

// ===== design/lz77_token_decompressor.sv =====
// top level of the lz77 token decompressor
//   port     dir   word                                      handshake
//   stream   in    in_byte, chunk_end                        valid/ready
//   result   out   out_bytes, byte_count, last_of_run,       valid/ready
//                  chunk_done, error_code
// tag, varint and literal words are accepted whenever the queue has room
// a match copy reads each byte and then writes it back through the single history port
// rst_n clears parser, queue and output state; history is not cleared
// the four-entry queue lets input run ahead while a copy or output stalls
`timescale 1ns / 1ps
module lz77_token_decompressor
(
    input  logic        clk,
    input  logic        rst_n,
    lztd_in_if.sink     stream,
    lztd_out_if.source  result
);

    logic           q_full, push, pop, avail;
    lztd_pkg::cmd_t push_cmd, head;

    lztd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .stream   (stream),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    lztd_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .avail    (avail),
        .head     (head)
    );

    lztd_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .avail  (avail),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

endmodule

// ===== bench/lz77_token_decompressor_tb.sv =====
// testbench of the lz77 token decompressor: directed and random chunks checked word by word
`timescale 1ns / 1ps
module lz77_token_decompressor_tb;

    typedef struct {
        logic [63:0] data;
        logic [3:0]  cnt;
        logic        last;
        logic        done;
        logic [2:0]  err;
    } decoded_t;

    logic clk;
    logic rst_n;
    lztd_in_if  in_ch ();
    lztd_out_if out_ch ();

    lz77_token_decompressor u_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (in_ch),
        .result (out_ch)
    );

    // decoder image
    lztd_pkg::phase_t ph;
    logic [31:0] acc;
    int          grp;
    logic [31:0] lit_left;
    int          mlen;
    int          produced;
    int          wptr;
    logic [2:0]  err_held;
    logic [7:0]  hist [lztd_pkg::WINDOW_BYTES];

    decoded_t    expected_q [$];
    logic [7:0]  chunk_bytes [$];
    int          chunk_produced;
    int          words_sent;
    int          results_seen;
    int          chunks_sent;
    int          errors_found;
    int          mismatches;
    int          cycles = 0;
    int          stall_left;
    bit          quiet;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("timeout with %0d words still expected", expected_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic void clear_decoder();
        ph       = lztd_pkg::PH_TAG;
        acc      = '0;
        grp      = 0;
        lit_left = '0;
        mlen     = 0;
        produced = 0;
        wptr     = 0;
        err_held = lztd_pkg::ERR_NONE;
    endfunction

    function automatic void store_hist(input logic [7:0] b);
        hist[wptr] = b;
        wptr = (wptr + 1 >= lztd_pkg::WINDOW_BYTES) ? 0 : wptr + 1;
        if (produced < lztd_pkg::WINDOW_BYTES)
            produced++;
    endfunction

    // returns 1 when complete, 0 when more groups follow, -1 on a long varint
    function automatic int feed_varint(input logic [7:0] b, output logic [31:0] val);
        acc = acc | (32'(b & lztd_pkg::GROUP_MASK) << (7 * (grp % 5)));
        grp++;
        val = acc;
        if ((b & lztd_pkg::CONT_BIT) != 0)
            return (grp >= 5) ? -1 : 0;
        acc = '0;
        grp = 0;
        return 1;
    endfunction

    function automatic void predict_word(input logic [7:0] b, input logic e);
        logic [2:0]  newerr;
        logic [31:0] val;
        int          v;
        int          cnt;
        int          idx;
        logic [7:0]  hb;
        logic [63:0] data;
        decoded_t    res [$];
        decoded_t    r;
        newerr = lztd_pkg::ERR_NONE;
        val = '0;
        if (err_held == lztd_pkg::ERR_NONE)
        begin
            case (ph)
                lztd_pkg::PH_TAG:
                begin
                    ph = (b == lztd_pkg::TAG_LITERAL) ? lztd_pkg::PH_LITLEN
                                                      : lztd_pkg::PH_MLEN;
                    acc = '0;
                    grp = 0;
                end
                lztd_pkg::PH_LITLEN:
                begin
                    v = feed_varint(b, val);
                    if (v < 0)
                        newerr = lztd_pkg::ERR_LONG_VARINT;
                    else if (v > 0)
                    begin
                        lit_left = val;
                        ph = (val == 0) ? lztd_pkg::PH_TAG : lztd_pkg::PH_LITDATA;
                    end
                end
                lztd_pkg::PH_LITDATA:
                begin
                    store_hist(b);
                    r = '{data: 64'(b), cnt: 4'd1, last: 1'b0, done: 1'b0,
                          err: lztd_pkg::ERR_NONE};
                    res.push_back(r);
                    lit_left = lit_left - 1;
                    if (lit_left == 0)
                        ph = lztd_pkg::PH_TAG;
                end
                lztd_pkg::PH_MLEN:
                begin
                    v = feed_varint(b, val);
                    if (v < 0)
                        newerr = lztd_pkg::ERR_LONG_VARINT;
                    else if (v > 0)
                    begin
                        if (val > lztd_pkg::MAX_MATCH)
                            newerr = lztd_pkg::ERR_LEN_LONG;
                        else
                        begin
                            mlen = int'(val);
                            ph = lztd_pkg::PH_MDIST;
                        end
                    end
                end
                default:
                begin
                    v = feed_varint(b, val);
                    if (v < 0)
                        newerr = lztd_pkg::ERR_LONG_VARINT;
                    else if (v > 0)
                    begin
                        if (val > lztd_pkg::WINDOW_BYTES)
                            newerr = lztd_pkg::ERR_BEYOND;
                        else if (val == 0 || val > produced)
                            newerr = lztd_pkg::ERR_BAD_DIST;
                        else
                        begin
                            data = '0;
                            cnt = 0;
                            for (int k = 0; k < mlen; k++)
                            begin
                                idx = (wptr + lztd_pkg::WINDOW_BYTES - int'(val))
                                      % lztd_pkg::WINDOW_BYTES;
                                hb = hist[idx];
                                store_hist(hb);
                                data = data | (64'(hb) << (8 * cnt));
                                cnt++;
                                if (cnt == lztd_pkg::OUT_LANES)
                                begin
                                    r = '{data: data, cnt: 4'(cnt), last: 1'b0, done: 1'b0,
                                          err: lztd_pkg::ERR_NONE};
                                    res.push_back(r);
                                    data = '0;
                                    cnt = 0;
                                end
                            end
                            if (cnt != 0)
                            begin
                                r = '{data: data, cnt: 4'(cnt), last: 1'b0, done: 1'b0,
                                      err: lztd_pkg::ERR_NONE};
                                res.push_back(r);
                            end
                        end
                        mlen = 0;
                        if (newerr == lztd_pkg::ERR_NONE)
                            ph = lztd_pkg::PH_TAG;
                    end
                end
            endcase
            if (newerr == lztd_pkg::ERR_NONE && e && ph != lztd_pkg::PH_TAG)
                newerr = lztd_pkg::ERR_TRUNCATED;
            if (newerr != lztd_pkg::ERR_NONE)
                err_held = newerr;
        end
        if (newerr != lztd_pkg::ERR_NONE || e)
        begin
            if (res.size() == 0)
            begin
                r = '{data: '0, cnt: '0, last: 1'b0, done: 1'b0, err: lztd_pkg::ERR_NONE};
                res.push_back(r);
            end
            res[res.size() - 1].err  = err_held;
            res[res.size() - 1].done = e;
        end
        if (res.size() > 0)
            res[res.size() - 1].last = 1'b1;
        if (e)
            clear_decoder();
        foreach (res[i])
            expected_q.push_back(res[i]);
    endfunction

    // result side: check each accepted word and draw the next stall
    always @(posedge clk)
    begin
        decoded_t want;
        int       n;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b1;
            stall_left = 0;
        end
        else if (out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: data %h count %0d", out_ch.out_bytes,
                             out_ch.byte_count);
            end
            else
            begin
                want = expected_q.pop_front();
                if (out_ch.out_bytes !== want.data || out_ch.byte_count !== want.cnt ||
                    out_ch.last_of_run !== want.last || out_ch.chunk_done !== want.done ||
                    out_ch.error_code !== want.err)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h/%0d/%b/%b/%0d got %h/%0d/%b/%b/%0d",
                                 want.data, want.cnt, want.last, want.done, want.err,
                                 out_ch.out_bytes, out_ch.byte_count, out_ch.last_of_run,
                                 out_ch.chunk_done, out_ch.error_code);
                end
            end
            n = quiet ? 0 : $urandom_range(0, 3);
            if (n != 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left = n;
            end
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            if (stall_left == 0)
                out_ch.ready <= 1'b1;
        end
    end

    task automatic send_word(input logic [7:0] b, input logic e);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.in_byte   <= b;
        in_ch.chunk_end <= e;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_word(b, e);
        words_sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    function automatic void push_leb128(input logic [31:0] value);
        logic [31:0] x;
        x = value;
        while (x > 127)
        begin
            chunk_bytes.push_back(8'(x & 32'h7f) | lztd_pkg::CONT_BIT);
            x = x >> 7;
        end
        chunk_bytes.push_back(8'(x));
    endfunction

    function automatic void put_literals(input int len);
        chunk_bytes.push_back(lztd_pkg::TAG_LITERAL);
        push_leb128(32'(len));
        for (int i = 0; i < len; i++)
            chunk_bytes.push_back(8'($urandom_range(0, 255)));
        chunk_produced += len;
    endfunction

    function automatic void put_match(input int len, input int offset);
        chunk_bytes.push_back(8'($urandom_range(1, 255)));
        push_leb128(32'(len));
        push_leb128(32'(offset));
        chunk_produced += len;
    endfunction

    task automatic send_chunk();
        for (int i = 0; i < chunk_bytes.size(); i++)
            send_word(chunk_bytes[i], i == chunk_bytes.size() - 1);
        chunk_bytes = {};
        chunk_produced = 0;
        chunks_sent++;
    endtask

    task automatic test_literals();
        chunk_bytes = {lztd_pkg::TAG_LITERAL, 8'd3, 8'h00, 8'hff, 8'h5a,
                       lztd_pkg::TAG_LITERAL, 8'd0};
        put_literals(2);
        send_chunk();
    endtask

    task automatic test_matches();
        put_literals(3);
        put_match(10, 1);
        put_match(0, 2);
        put_match(7, 13);
        put_match(lztd_pkg::MAX_MATCH, 1);
        send_chunk();
        chunk_bytes = {8'hff};
        send_chunk();
        drain();
    endtask

    task automatic test_errors();
        put_literals(2);
        put_match(4, 0);
        chunk_bytes.push_back(8'h33);
        send_chunk();
        put_literals(2);
        put_match(4, 3);
        send_chunk();
        put_literals(1);
        put_match(4, lztd_pkg::WINDOW_BYTES + 1);
        send_chunk();
        put_literals(1);
        put_match(4, lztd_pkg::WINDOW_BYTES);
        send_chunk();
        put_literals(1);
        put_match(lztd_pkg::MAX_MATCH + 1, 1);
        send_chunk();
        // varint that never stops
        chunk_bytes = {8'h01, 8'h80, 8'h80, 8'hff, 8'h80, 8'h80, 8'h12};
        send_chunk();
        // five-group length whose top bits fall off, cut short
        chunk_bytes = {lztd_pkg::TAG_LITERAL, 8'h80, 8'h80, 8'h80, 8'h80, 8'h7f,
                       8'h11, 8'h22};
        send_chunk();
    endtask

    task automatic test_random();
        int kind;
        while (words_sent < 300)
        begin
            if ($urandom_range(0, 5) == 0)
                quiet = !quiet;
            if ($urandom_range(0, 9) == 0)
                drain();
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                repeat ($urandom_range(1, 6))
                    chunk_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                put_literals($urandom_range(1, 6));
                repeat ($urandom_range(1, 5))
                begin
                    if ($urandom_range(0, 1) == 0)
                        put_literals($urandom_range(0, 6));
                    else
                        put_match(($urandom_range(0, 30) == 0) ? lztd_pkg::MAX_MATCH
                                                               : $urandom_range(0, 20),
                                  $urandom_range(1, chunk_produced));
                end
                case (kind)
                    1: put_match($urandom_range(1, 9), chunk_produced + $urandom_range(1, 5));
                    2: put_match($urandom_range(lztd_pkg::MAX_MATCH + 1, 600), 1);
                    3: repeat ($urandom_range(1, 3)) void'(chunk_bytes.pop_back());
                    default: ;
                endcase
            end
            send_chunk();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.in_byte = '0;
        in_ch.chunk_end = 1'b0;
        quiet = 1'b0;
        words_sent = 0;
        results_seen = 0;
        chunks_sent = 0;
        mismatches = 0;
        chunk_produced = 0;
        clear_decoder();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_literals();
        test_matches();
        test_errors();
        test_random();
        drain();
        if (expected_q.size() != 0)
            mismatches++;
        $display("sent %0d words in %0d chunks, checked %0d decoded words",
                 words_sent, chunks_sent, results_seen);
        $display("literal runs, overlapping copies, every error code and cut-short chunks");
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
